// ----- rtl/rrsp_pkg.sv -----
package rrsp_pkg;

    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [3:0] K_DATA       = 4'd0;
    localparam logic [3:0] K_STATUS_END = 4'd1;
    localparam logic [3:0] K_ERROR_END  = 4'd2;
    localparam logic [3:0] K_INTEGER    = 4'd3;
    localparam logic [3:0] K_BULK_HDR   = 4'd4;
    localparam logic [3:0] K_BULK_END   = 4'd5;
    localparam logic [3:0] K_NIL        = 4'd6;
    localparam logic [3:0] K_ARRAY_HDR  = 4'd7;
    localparam logic [3:0] K_DONE       = 4'd8;
    localparam logic [3:0] K_PROTO_ERR  = 4'd9;

    localparam logic [1:0] CAUSE_NONE = 2'd0;
    localparam logic [1:0] CAUSE_BAD  = 2'd1;
    localparam logic [1:0] CAUSE_DEEP = 2'd2;

    // what the back end does with the level stack before it emits the word's tokens
    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_ADV   = 2'd1,
        OP_PUSH  = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef struct packed {
        logic [3:0]  kind;
        logic [63:0] value;
        logic [7:0]  data;
        logic [1:0]  cause;
        logic        has_second;
        logic [7:0]  second_data;
        t_op         op;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ----- rtl/rrsp_fifo.sv -----
module rrsp_fifo import rrsp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_entry  i_entry,
    input  logic    i_pop,
    output t_entry  o_entry,
    output t_q_stat o_stat
);

    t_entry     r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_entry      = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == 2'd2);
    assign o_stat.empty = (r_cnt == 2'd0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

// ----- rtl/rrsp_front.sv -----
module rrsp_front import rrsp_pkg::*; #(
    parameter int MAX_NEST = 8,
    parameter int LW = $clog2(MAX_NEST + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [7:0]    i_stream_byte,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [LW-1:0] i_level,
    input  logic          i_back_idle,
    input  t_q_stat       i_q_stat,
    output logic          o_push,
    output t_entry        o_entry
);

    typedef enum logic [7:0] {
        P_TYPE   = 8'b0000_0001,
        P_LINE   = 8'b0000_0010,
        P_NSTART = 8'b0000_0100,
        P_NDIG   = 8'b0000_1000,
        P_NSKIP  = 8'b0001_0000,
        P_BDATA  = 8'b0010_0000,
        P_BCR    = 8'b0100_0000,
        P_BLF    = 8'b1000_0000
    } t_phase;

    localparam logic [2:0] IT_INVALID = 3'd0;
    localparam logic [2:0] IT_STATUS  = 3'd1;
    localparam logic [2:0] IT_ERROR   = 3'd2;
    localparam logic [2:0] IT_INTEGER = 3'd3;
    localparam logic [2:0] IT_BULK    = 3'd4;
    localparam logic [2:0] IT_ARRAY   = 3'd5;

    t_phase      r_phase, n_phase;
    logic [2:0]  r_item, n_item;
    logic [63:0] r_acc, n_acc;
    logic        r_neg, n_neg;
    logic [63:0] r_bulk, n_bulk;
    logic        r_pcr, n_pcr;

    logic        emit;
    t_entry      ent;
    t_phase      eff;
    logic        do_num;
    logic [63:0] v;
    logic [31:0] c32;
    logic [63:0] bulk_dec;
    logic        accept;

    // a type byte reads the level pointer, so the back end must have settled
    assign o_ready = !i_q_stat.full && ((r_phase != P_TYPE) || i_back_idle);
    assign accept  = i_valid && o_ready;
    assign o_push  = accept && emit;
    assign o_entry = ent;

    assign v        = r_neg ? (64'd0 - r_acc) : r_acc;
    assign c32      = v[31:0];
    assign bulk_dec = r_bulk - 64'd1;

    always_comb begin
        n_phase = r_phase;
        n_item  = r_item;
        n_acc   = r_acc;
        n_neg   = r_neg;
        n_bulk  = r_bulk;
        n_pcr   = r_pcr;
        emit    = 1'b0;
        ent     = '0;
        eff     = r_phase;
        do_num  = 1'b0;
        unique case (r_phase)
            P_TYPE: begin
                n_item = IT_INVALID;
                n_acc  = '0;
                n_neg  = 1'b0;
                n_pcr  = 1'b0;
                case (i_stream_byte)
                    CH_PLUS: begin
                        n_item  = IT_STATUS;
                        n_phase = P_LINE;
                    end
                    CH_MINUS: begin
                        n_item  = IT_ERROR;
                        n_phase = P_LINE;
                    end
                    CH_COLON: begin
                        n_item  = IT_INTEGER;
                        n_phase = P_NSTART;
                    end
                    CH_DOLLAR: begin
                        n_item  = IT_BULK;
                        n_phase = P_NSTART;
                    end
                    CH_STAR: begin
                        if (i_level >= LW'(MAX_NEST)) begin
                            emit      = 1'b1;
                            ent.kind  = K_PROTO_ERR;
                            ent.cause = CAUSE_DEEP;
                            ent.op    = OP_CLEAR;
                            n_bulk    = '0;
                        end else begin
                            n_item  = IT_ARRAY;
                            n_phase = P_NSTART;
                        end
                    end
                    default: begin
                        emit      = 1'b1;
                        ent.kind  = K_PROTO_ERR;
                        ent.cause = CAUSE_BAD;
                        ent.op    = OP_CLEAR;
                        n_bulk    = '0;
                    end
                endcase
            end
            P_LINE: begin
                if (r_pcr && i_stream_byte == CH_LF) begin
                    emit     = 1'b1;
                    ent.kind = (r_item == IT_ERROR) ? K_ERROR_END : K_STATUS_END;
                    ent.op   = OP_ADV;
                    n_phase  = P_TYPE;
                    n_item   = IT_INVALID;
                    n_acc    = '0;
                    n_neg    = 1'b0;
                    n_pcr    = 1'b0;
                end else if (r_pcr) begin
                    // lone cr passes as data, then this word is handled
                    emit     = 1'b1;
                    ent.kind = K_DATA;
                    ent.data = CH_CR;
                    if (i_stream_byte == CH_CR) begin
                        n_pcr = 1'b1;
                    end else begin
                        n_pcr           = 1'b0;
                        ent.has_second  = 1'b1;
                        ent.second_data = i_stream_byte;
                    end
                end else if (i_stream_byte == CH_CR) begin
                    n_pcr = 1'b1;
                end else begin
                    emit     = 1'b1;
                    ent.kind = K_DATA;
                    ent.data = i_stream_byte;
                end
            end
            P_NSTART, P_NDIG, P_NSKIP: begin
                do_num = 1'b1;
                if (r_pcr && i_stream_byte == CH_LF) begin
                    do_num = 1'b0;
                    emit   = 1'b1;
                    n_phase = P_TYPE;
                    n_item  = IT_INVALID;
                    n_acc   = '0;
                    n_neg   = 1'b0;
                    n_pcr   = 1'b0;
                    if (r_item == IT_INTEGER) begin
                        ent.kind  = K_INTEGER;
                        ent.value = v;
                        ent.op    = OP_ADV;
                    end else if (r_item == IT_BULK) begin
                        ent.value = v;
                        if (v[63]) begin
                            ent.kind = K_NIL;
                            ent.op   = OP_ADV;
                        end else begin
                            ent.kind = K_BULK_HDR;
                            ent.op   = OP_NONE;
                            n_item   = r_item;
                            n_acc    = r_acc;
                            n_neg    = r_neg;
                            n_bulk   = v;
                            n_phase  = (v == 64'd0) ? P_BCR : P_BDATA;
                        end
                    end else begin
                        ent.value = {{32{c32[31]}}, c32};
                        if (c32 == 32'hFFFF_FFFF) begin
                            ent.kind = K_NIL;
                            ent.op   = OP_ADV;
                        end else begin
                            ent.kind = K_ARRAY_HDR;
                            ent.op   = (c32 != 32'd0 && !c32[31]) ? OP_PUSH : OP_ADV;
                        end
                    end
                end else if (r_pcr) begin
                    n_pcr   = 1'b0;
                    eff     = P_NSKIP;
                    n_phase = P_NSKIP;
                end
                if (do_num) begin
                    if (i_stream_byte == CH_CR) begin
                        n_pcr = 1'b1;
                    end else if (eff == P_NSKIP) begin
                        n_phase = P_NSKIP;
                    end else if (i_stream_byte >= CH_ZERO && i_stream_byte <= CH_NINE) begin
                        n_acc   = (r_acc << 3) + (r_acc << 1)
                                + {56'd0, i_stream_byte - CH_ZERO};
                        n_phase = P_NDIG;
                    end else if (eff == P_NSTART &&
                                 (i_stream_byte == CH_MINUS || i_stream_byte == CH_PLUS)) begin
                        n_neg   = (i_stream_byte == CH_MINUS);
                        n_phase = P_NDIG;
                    end else begin
                        n_phase = P_NSKIP;
                    end
                end
            end
            P_BDATA: begin
                emit     = 1'b1;
                ent.kind = K_DATA;
                ent.data = i_stream_byte;
                n_bulk   = bulk_dec;
                if (bulk_dec == 64'd0) begin
                    n_phase = P_BCR;
                end
            end
            P_BCR: begin
                if (i_stream_byte == CH_CR) begin
                    n_phase = P_BLF;
                end else begin
                    emit      = 1'b1;
                    ent.kind  = K_PROTO_ERR;
                    ent.cause = CAUSE_BAD;
                    ent.op    = OP_CLEAR;
                    n_bulk    = '0;
                    n_phase   = P_TYPE;
                    n_item    = IT_INVALID;
                    n_acc     = '0;
                    n_neg     = 1'b0;
                    n_pcr     = 1'b0;
                end
            end
            P_BLF: begin
                emit    = 1'b1;
                n_phase = P_TYPE;
                n_item  = IT_INVALID;
                n_acc   = '0;
                n_neg   = 1'b0;
                n_pcr   = 1'b0;
                if (i_stream_byte == CH_LF) begin
                    ent.kind = K_BULK_END;
                    ent.op   = OP_ADV;
                end else begin
                    ent.kind  = K_PROTO_ERR;
                    ent.cause = CAUSE_BAD;
                    ent.op    = OP_CLEAR;
                    n_bulk    = '0;
                end
            end
            default: begin
                n_phase = P_TYPE;
                n_item  = IT_INVALID;
                n_acc   = '0;
                n_neg   = 1'b0;
                n_pcr   = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_TYPE;
            r_item  <= IT_INVALID;
            r_acc   <= '0;
            r_neg   <= 1'b0;
            r_bulk  <= '0;
            r_pcr   <= 1'b0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_item  <= n_item;
            r_acc   <= n_acc;
            r_neg   <= n_neg;
            r_bulk  <= n_bulk;
            r_pcr   <= n_pcr;
        end
    end

endmodule

// ----- rtl/rrsp_back.sv -----
module rrsp_back import rrsp_pkg::*; #(
    parameter int MAX_NEST = 8,
    parameter int LW = $clog2(MAX_NEST + 1),
    parameter int SW = (MAX_NEST > 1) ? $clog2(MAX_NEST) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_entry             i_entry,
    input  t_q_stat            i_q_stat,
    output logic               o_pop,
    output logic               o_back_idle,
    output logic [LW-1:0]      o_level,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [3:0]         o_token_kind,
    output logic signed [63:0] o_token_value,
    output logic [7:0]         o_data_byte,
    output logic [3:0]         o_nest_level,
    output logic [1:0]         o_error_cause,
    output logic               o_last_of_run
);

    typedef enum logic [4:0] {
        B_IDLE = 5'b00001,
        B_WALK = 5'b00010,
        B_TOK0 = 5'b00100,
        B_TOK1 = 5'b01000,
        B_DONE = 5'b10000
    } t_bstate;

    t_bstate       r_state, n_state;
    t_entry        r_ent;
    logic [LW-1:0] r_lp, n_lp;
    logic [LW-1:0] r_lvl;
    logic          r_done, n_done;
    logic [31:0]   r_stack [MAX_NEST];

    logic          out_free;
    logic [LW-1:0] top_lp;
    logic [31:0]   rem;
    logic          stack_we;
    logic [SW-1:0] stack_idx;
    logic [31:0]   stack_wd;
    logic          emit;
    logic [3:0]    e_kind;
    logic [63:0]   e_value;
    logic [7:0]    e_data;
    logic [3:0]    e_level;
    logic [1:0]    e_cause;
    logic          e_last;

    logic          r_ovalid;
    logic [3:0]    r_okind;
    logic [63:0]   r_ovalue;
    logic [7:0]    r_odata;
    logic [3:0]    r_olevel;
    logic [1:0]    r_ocause;
    logic          r_olast;

    assign out_free    = !r_ovalid || i_ready;
    assign o_pop       = (r_state == B_IDLE) && !i_q_stat.empty;
    assign o_back_idle = (r_state == B_IDLE) && i_q_stat.empty;
    assign o_level     = r_lp;
    assign top_lp      = r_lp - LW'(1);
    assign rem         = r_stack[top_lp[SW-1:0]] - 32'd1;

    always_comb begin
        n_state   = r_state;
        n_lp      = r_lp;
        n_done    = r_done;
        stack_we  = 1'b0;
        stack_idx = r_lp[SW-1:0];
        stack_wd  = i_entry.value[31:0];
        emit      = 1'b0;
        e_kind    = r_ent.kind;
        e_value   = r_ent.value;
        e_data    = r_ent.data;
        e_level   = (r_ent.kind == K_PROTO_ERR) ? 4'd0 : 4'(r_lvl);
        e_cause   = r_ent.cause;
        e_last    = !r_ent.has_second && !r_done;
        unique case (r_state)
            B_IDLE: begin
                if (o_pop) begin
                    n_done  = 1'b0;
                    n_state = B_TOK0;
                    unique case (i_entry.op)
                        OP_CLEAR: n_lp = '0;
                        OP_PUSH: begin
                            stack_we = 1'b1;
                            n_lp     = r_lp + LW'(1);
                        end
                        OP_ADV: begin
                            if (r_lp == '0) begin
                                n_done = 1'b1;
                            end else begin
                                n_state = B_WALK;
                            end
                        end
                        default: n_state = B_TOK0;
                    endcase
                end
            end
            B_WALK: begin
                // one level per cycle; a level that runs out closes its array
                stack_we  = 1'b1;
                stack_idx = top_lp[SW-1:0];
                stack_wd  = rem;
                if (rem != 32'd0) begin
                    n_state = B_TOK0;
                end else begin
                    n_lp = top_lp;
                    if (top_lp == '0) begin
                        n_done  = 1'b1;
                        n_state = B_TOK0;
                    end
                end
            end
            B_TOK0: begin
                if (out_free) begin
                    emit = 1'b1;
                    if (r_ent.has_second) begin
                        n_state = B_TOK1;
                    end else if (r_done) begin
                        n_state = B_DONE;
                    end else begin
                        n_state = B_IDLE;
                    end
                end
            end
            B_TOK1: begin
                e_kind  = K_DATA;
                e_value = '0;
                e_data  = r_ent.second_data;
                e_cause = CAUSE_NONE;
                e_last  = !r_done;
                if (out_free) begin
                    emit    = 1'b1;
                    n_state = r_done ? B_DONE : B_IDLE;
                end
            end
            B_DONE: begin
                e_kind  = K_DONE;
                e_value = '0;
                e_data  = '0;
                e_level = 4'd0;
                e_cause = CAUSE_NONE;
                e_last  = 1'b1;
                if (out_free) begin
                    emit    = 1'b1;
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (stack_we) begin
            r_stack[stack_idx] <= stack_wd;
        end
        if (o_pop) begin
            r_ent <= i_entry;
            r_lvl <= r_lp;
        end
        if (emit) begin
            r_okind  <= e_kind;
            r_ovalue <= e_value;
            r_odata  <= e_data;
            r_olevel <= e_level;
            r_ocause <= e_cause;
            r_olast  <= e_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_lp     <= '0;
            r_done   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_lp    <= n_lp;
            r_done  <= n_done;
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_valid       = r_ovalid;
    assign o_token_kind  = r_okind;
    assign o_token_value = r_ovalue;
    assign o_data_byte   = r_odata;
    assign o_nest_level  = r_olevel;
    assign o_error_cause = r_ocause;
    assign o_last_of_run = r_olast;

endmodule

// ----- rtl/resp_reply_stream_parser_unit.sv -----
// channel   direction  handshake           payload
// input     in         i_valid / o_ready   i_stream_byte
// output    out        o_valid / i_ready   o_token_kind, o_token_value, o_data_byte,
//                                          o_nest_level, o_error_cause, o_last_of_run
//
// the front end takes one word per cycle into a two-entry queue when it is not full;
// a type word waits until the back end and the queue are empty, since it reads the level
// pointer; the back end takes an entry, checks the array levels when an item completes
// (up to MAX_NEST levels), and then emits the entry's tokens
// synchronous active-low reset clears control state; the level stack is not cleared
// either side may stall; the output register holds a token until it is taken
module resp_reply_stream_parser_unit import rrsp_pkg::*; #(
    parameter int MAX_NEST = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [7:0]         i_stream_byte,
    input  logic               i_valid,
    output logic               o_ready,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [3:0]         o_token_kind,
    output logic signed [63:0] o_token_value,
    output logic [7:0]         o_data_byte,
    output logic [3:0]         o_nest_level,
    output logic [1:0]         o_error_cause,
    output logic               o_last_of_run
);

    localparam int LW = $clog2(MAX_NEST + 1);

    logic          q_push;
    logic          q_pop;
    t_entry        q_in;
    t_entry        q_out;
    t_q_stat       q_stat;
    logic          back_idle;
    logic [LW-1:0] level;

    rrsp_front #(
        .MAX_NEST (MAX_NEST),
        .LW       (LW)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_stream_byte (i_stream_byte),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_level       (level),
        .i_back_idle   (back_idle),
        .i_q_stat      (q_stat),
        .o_push        (q_push),
        .o_entry       (q_in)
    );

    rrsp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .i_pop   (q_pop),
        .o_entry (q_out),
        .o_stat  (q_stat)
    );

    rrsp_back #(
        .MAX_NEST (MAX_NEST),
        .LW       (LW)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_entry       (q_out),
        .i_q_stat      (q_stat),
        .o_pop         (q_pop),
        .o_back_idle   (back_idle),
        .o_level       (level),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_token_kind  (o_token_kind),
        .o_token_value (o_token_value),
        .o_data_byte   (o_data_byte),
        .o_nest_level  (o_nest_level),
        .o_error_cause (o_error_cause),
        .o_last_of_run (o_last_of_run)
    );

endmodule
